/* sv/sncs_pkg.sv */
// Shared types, codes and helpers of the serial NOR flash command sequencer.
`timescale 1ns / 1ps
`default_nettype none
package sncs_pkg;

    localparam int unsigned PAGE_BYTES_DEF   = 256;
    localparam int unsigned SECTOR_BYTES_DEF = 4096;
    localparam int unsigned QUEUE_DEPTH      = 2;

    // input item kinds (tuser)
    localparam logic [1:0] OP_REQ   = 2'd0;
    localparam logic [1:0] OP_REPLY = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;
    localparam logic [1:0] OP_WBYTE = 2'd3;

    // host commands
    localparam logic [2:0] CMD_INIT   = 3'd0;
    localparam logic [2:0] CMD_RDID   = 3'd1;
    localparam logic [2:0] CMD_READ   = 3'd2;
    localparam logic [2:0] CMD_PROG   = 3'd3;
    localparam logic [2:0] CMD_SERASE = 3'd4;
    localparam logic [2:0] CMD_CERASE = 3'd5;
    localparam logic [2:0] CMD_PDOWN  = 3'd6;
    localparam logic [2:0] CMD_WAKE   = 3'd7;

    // result kinds
    localparam logic [2:0] K_SEND   = 3'd0;
    localparam logic [2:0] K_REL    = 3'd1;
    localparam logic [2:0] K_RDBYTE = 3'd2;
    localparam logic [2:0] K_NEED   = 3'd3;
    localparam logic [2:0] K_DELAY  = 3'd4;
    localparam logic [2:0] K_DONE   = 3'd5;

    // completion status
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_TIMEOUT  = 3'd1;
    localparam logic [2:0] ST_NOTFOUND = 3'd2;
    localparam logic [2:0] ST_NOTINIT  = 3'd3;
    localparam logic [2:0] ST_RANGE    = 3'd4;
    localparam logic [2:0] ST_VERIFY   = 3'd5;

    // flash opcodes
    localparam logic [7:0] FL_WREN  = 8'h06;
    localparam logic [7:0] FL_RDSR  = 8'h05;
    localparam logic [7:0] FL_READ  = 8'h03;
    localparam logic [7:0] FL_PP    = 8'h02;
    localparam logic [7:0] FL_SE    = 8'h20;
    localparam logic [7:0] FL_CE    = 8'hC7;
    localparam logic [7:0] FL_DP    = 8'hB9;
    localparam logic [7:0] FL_RDP   = 8'hAB;
    localparam logic [7:0] FL_RDID  = 8'h9F;
    localparam logic [7:0] FL_DUMMY = 8'hFF;

    localparam logic [17:0] POLL_MAX = 18'h3FFFF;
    localparam logic [7:0]  BYTE_MAX = 8'hFF;

    // configuration register indexes
    localparam logic [2:0] REG_ABC    = 3'd0;
    localparam logic [2:0] REG_CAP    = 3'd1;
    localparam logic [2:0] REG_ID     = 3'd2;
    localparam logic [2:0] REG_BYTETO = 3'd3;
    localparam logic [2:0] REG_PAGETO = 3'd4;
    localparam logic [2:0] REG_SECTO  = 3'd5;
    localparam logic [2:0] REG_CHIPTO = 3'd6;

    typedef struct packed {
        logic [2:0]  abc;
        logic [31:0] cap;
        logic [23:0] exp_id;
        logic [7:0]  byte_to;
        logic [15:0] page_to;
        logic [15:0] sec_to;
        logic [17:0] chip_to;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  byte_out;
        logic [2:0]  status;
        logic [23:0] device_id;
    } t_res;

    // all result beats caused by one input item
    typedef struct packed {
        t_res [3:0] res;
        logic [2:0] cnt;
    } t_bundle;

    function automatic t_bundle add_res(t_bundle b, logic [2:0] k, logic [7:0] d,
                                        logic [2:0] s, logic [23:0] id);
        t_bundle o;
        o = b;
        if (b.cnt < 3'd4) begin
            o.res[b.cnt[1:0]] = '{kind: k, byte_out: d, status: s, device_id: id};
            o.cnt = b.cnt + 3'd1;
        end
        return o;
    endfunction

endpackage
`default_nettype wire

/* sv/sncs_front.sv */
// Front end: accepts items, steps the command state machine, builds result bundles.
`timescale 1ns / 1ps
`default_nettype none
module sncs_front #(
    parameter int unsigned PAGE_BYTES   = sncs_pkg::PAGE_BYTES_DEF,
    parameter int unsigned SECTOR_BYTES = sncs_pkg::SECTOR_BYTES_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire logic [1:0]        i_op,
    input  wire logic [2:0]        i_command,
    input  wire logic [31:0]       i_address,
    input  wire logic [31:0]       i_length,
    input  wire logic [7:0]        i_data_in,
    input  wire sncs_pkg::t_cfg    i_cfg,
    output logic                   o_push,
    output sncs_pkg::t_bundle      o_bundle
);

    typedef enum logic [15:0] {
        PH_IDLE      = 16'h0001,
        PH_WAKE      = 16'h0002,
        PH_ID_CMD    = 16'h0004,
        PH_ID_BYTE   = 16'h0008,
        PH_PRE_CMD   = 16'h0010,
        PH_PRE_STAT  = 16'h0020,
        PH_WE        = 16'h0040,
        PH_WEL_CMD   = 16'h0080,
        PH_WEL_STAT  = 16'h0100,
        PH_CMD       = 16'h0200,
        PH_ADDR      = 16'h0400,
        PH_READ      = 16'h0800,
        PH_HOST      = 16'h1000,
        PH_PROG      = 16'h2000,
        PH_POST_CMD  = 16'h4000,
        PH_POST_STAT = 16'h8000
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [2:0]  r_cmd, n_cmd;
    logic [31:0] r_waddr, n_waddr;
    logic [31:0] r_left, n_left;
    logic [1:0]  r_aidx, n_aidx;
    logic [17:0] r_poll, n_poll;
    logic [7:0]  r_bel, n_bel;
    logic [23:0] r_id, n_id;
    logic        r_bus, n_bus;
    logic        r_init, n_init;

    sncs_pkg::t_bundle b;

    logic        ac4;
    logic        range_ok;
    logic        page_over;
    logic [31:0] addr_in_page;
    logic [31:0] addr_in_sector;
    logic        post;
    logic [17:0] limit;
    logic [23:0] id_next;
    logic [1:0]  aidx_inc;
    logic [7:0]  bel_inc;

    function automatic logic [7:0] addr_byte(logic [31:0] a, logic [1:0] idx, logic four);
        logic [1:0] sel;
        sel = four ? (2'd3 - idx) : (2'd2 - idx);
        unique case (sel)
            2'd0: return a[7:0];
            2'd1: return a[15:8];
            2'd2: return a[23:16];
            2'd3: return a[31:24];
            default: return a[7:0];
        endcase
    endfunction

    assign ac4            = (i_cfg.abc == 3'd4);
    assign addr_in_page   = i_address % PAGE_BYTES;
    assign addr_in_sector = i_address % SECTOR_BYTES;
    assign range_ok       = (i_address <= i_cfg.cap) && (i_length <= (i_cfg.cap - i_address));
    assign page_over      = ({1'b0, addr_in_page} + {1'b0, i_length}) > 33'(PAGE_BYTES);
    assign post           = (r_phase == PH_POST_STAT);
    assign limit          = (r_cmd == sncs_pkg::CMD_PROG) ? {2'b0, i_cfg.page_to} :
                            (post && r_cmd == sncs_pkg::CMD_CERASE) ? i_cfg.chip_to :
                            {2'b0, i_cfg.sec_to};
    assign id_next        = {r_id[15:0], i_data_in};
    assign aidx_inc       = r_aidx + 2'd1;
    assign bel_inc        = (r_bel == sncs_pkg::BYTE_MAX) ? r_bel : r_bel + 8'd1;

    always_comb begin
        b       = '0;
        n_phase = r_phase;
        n_cmd   = r_cmd;
        n_waddr = r_waddr;
        n_left  = r_left;
        n_aidx  = r_aidx;
        n_poll  = r_poll;
        n_bel   = r_bel;
        n_id    = r_id;
        n_bus   = r_bus;
        n_init  = r_init;
        if (i_accept) begin
            unique case (i_op)
                sncs_pkg::OP_REQ: begin
                    if (r_phase == PH_IDLE) begin
                        n_cmd = i_command;
                        if (i_command == sncs_pkg::CMD_INIT ||
                            i_command == sncs_pkg::CMD_WAKE) begin
                            if (i_command == sncs_pkg::CMD_INIT) begin
                                n_bus  = 1'b1;
                                n_init = 1'b0;
                            end
                            if (i_command == sncs_pkg::CMD_WAKE && !r_bus) begin
                                b = sncs_pkg::add_res(b, sncs_pkg::K_DONE, 8'd0,
                                                      sncs_pkg::ST_NOTINIT, 24'd0);
                                n_phase = PH_IDLE;
                            end else begin
                                b = sncs_pkg::add_res(b, sncs_pkg::K_SEND, sncs_pkg::FL_RDP,
                                                      sncs_pkg::ST_OK, 24'd0);
                                n_bel   = '0;
                                n_phase = PH_WAKE;
                            end
                        end else if (i_command == sncs_pkg::CMD_RDID) begin
                            if (!r_bus) begin
                                b = sncs_pkg::add_res(b, sncs_pkg::K_DONE, 8'd0,
                                                      sncs_pkg::ST_NOTINIT, 24'd0);
                            end else begin
                                n_id   = '0;
                                n_aidx = '0;
                                b = sncs_pkg::add_res(b, sncs_pkg::K_SEND, sncs_pkg::FL_RDID,
                                                      sncs_pkg::ST_OK, 24'd0);
                                n_bel   = '0;
                                n_phase = PH_ID_CMD;
                            end
                        end else if (!r_init) begin
                            b = sncs_pkg::add_res(b, sncs_pkg::K_DONE, 8'd0,
                                                  sncs_pkg::ST_NOTINIT, 24'd0);
                        end else begin
                            n_waddr = i_address;
                            n_left  = i_length;
                            if (i_command == sncs_pkg::CMD_READ ||
                                i_command == sncs_pkg::CMD_PROG) begin
                                if (!range_ok ||
                                    (i_command == sncs_pkg::CMD_PROG && page_over)) begin
                                    b = sncs_pkg::add_res(b, sncs_pkg::K_DONE, 8'd0,
                                                          sncs_pkg::ST_RANGE, 24'd0);
                                end else if (i_length == 32'd0) begin
                                    b = sncs_pkg::add_res(b, sncs_pkg::K_DONE, 8'd0,
                                                          sncs_pkg::ST_OK, 24'd0);
                                end else if (i_command == sncs_pkg::CMD_READ) begin
                                    b = sncs_pkg::add_res(b, sncs_pkg::K_SEND,
                                                          sncs_pkg::FL_READ,
                                                          sncs_pkg::ST_OK, 24'd0);
                                    n_bel   = '0;
                                    n_phase = PH_CMD;
                                end else begin
                                    n_poll = '0;
                                    b = sncs_pkg::add_res(b, sncs_pkg::K_SEND,
                                                          sncs_pkg::FL_RDSR,
                                                          sncs_pkg::ST_OK, 24'd0);
                                    n_bel   = '0;
                                    n_phase = PH_PRE_CMD;
                                end
                            end else if (i_command == sncs_pkg::CMD_SERASE &&
                                         i_address >= i_cfg.cap) begin
                                b = sncs_pkg::add_res(b, sncs_pkg::K_DONE, 8'd0,
                                                      sncs_pkg::ST_RANGE, 24'd0);
                            end else begin
                                if (i_command == sncs_pkg::CMD_SERASE) begin
                                    n_waddr = i_address - addr_in_sector;
                                end
                                n_poll = '0;
                                b = sncs_pkg::add_res(b, sncs_pkg::K_SEND, sncs_pkg::FL_RDSR,
                                                      sncs_pkg::ST_OK, 24'd0);
                                n_bel   = '0;
                                n_phase = PH_PRE_CMD;
                            end
                        end
                    end
                end
                sncs_pkg::OP_REPLY: begin
                    unique case (r_phase)
                        PH_WAKE: begin
                            b = sncs_pkg::add_res(b, sncs_pkg::K_REL, 8'd0, sncs_pkg::ST_OK, 24'd0);
                            b = sncs_pkg::add_res(b, sncs_pkg::K_DELAY, 8'd0,
                                                  sncs_pkg::ST_OK, 24'd0);
                            if (r_cmd == sncs_pkg::CMD_INIT) begin
                                n_id   = '0;
                                n_aidx = '0;
                                b = sncs_pkg::add_res(b, sncs_pkg::K_SEND, sncs_pkg::FL_RDID,
                                                      sncs_pkg::ST_OK, 24'd0);
                                n_bel   = '0;
                                n_phase = PH_ID_CMD;
                            end else begin
                                b = sncs_pkg::add_res(b, sncs_pkg::K_DONE, 8'd0,
                                                      sncs_pkg::ST_OK, 24'd0);
                                n_phase = PH_IDLE;
                            end
                        end
                        PH_ID_CMD: begin
                            n_aidx = '0;
                            b = sncs_pkg::add_res(b, sncs_pkg::K_SEND, sncs_pkg::FL_DUMMY,
                                                  sncs_pkg::ST_OK, 24'd0);
                            n_bel   = '0;
                            n_phase = PH_ID_BYTE;
                        end
                        PH_ID_BYTE: begin
                            n_id   = id_next;
                            n_aidx = aidx_inc;
                            if (aidx_inc != 2'd3) begin
                                b = sncs_pkg::add_res(b, sncs_pkg::K_SEND, sncs_pkg::FL_DUMMY,
                                                      sncs_pkg::ST_OK, 24'd0);
                                n_bel = '0;
                            end else begin
                                b = sncs_pkg::add_res(b, sncs_pkg::K_REL, 8'd0,
                                                      sncs_pkg::ST_OK, 24'd0);
                                n_phase = PH_IDLE;
                                if (r_cmd != sncs_pkg::CMD_INIT) begin
                                    b = sncs_pkg::add_res(b, sncs_pkg::K_DONE, 8'd0,
                                                          sncs_pkg::ST_OK, id_next);
                                end else if (id_next == i_cfg.exp_id) begin
                                    n_init = 1'b1;
                                    b = sncs_pkg::add_res(b, sncs_pkg::K_DONE, 8'd0,
                                                          sncs_pkg::ST_OK, id_next);
                                end else begin
                                    b = sncs_pkg::add_res(b, sncs_pkg::K_DONE, 8'd0,
                                                          sncs_pkg::ST_NOTFOUND, id_next);
                                end
                            end
                        end
                        PH_PRE_CMD, PH_POST_CMD: begin
                            b = sncs_pkg::add_res(b, sncs_pkg::K_SEND, sncs_pkg::FL_DUMMY,
                                                  sncs_pkg::ST_OK, 24'd0);
                            n_bel   = '0;
                            n_phase = (r_phase == PH_PRE_CMD) ? PH_PRE_STAT : PH_POST_STAT;
                        end
                        PH_PRE_STAT, PH_POST_STAT: begin
                            b = sncs_pkg::add_res(b, sncs_pkg::K_REL, 8'd0, sncs_pkg::ST_OK, 24'd0);
                            if (!i_data_in[0]) begin
                                if (post) begin
                                    b = sncs_pkg::add_res(b, sncs_pkg::K_DONE, 8'd0,
                                                          sncs_pkg::ST_OK, 24'd0);
                                    n_phase = PH_IDLE;
                                end else if (r_cmd == sncs_pkg::CMD_PDOWN) begin
                                    b = sncs_pkg::add_res(b, sncs_pkg::K_SEND, sncs_pkg::FL_DP,
                                                          sncs_pkg::ST_OK, 24'd0);
                                    n_bel   = '0;
                                    n_phase = PH_CMD;
                                end else begin
                                    b = sncs_pkg::add_res(b, sncs_pkg::K_SEND,
                                                          sncs_pkg::FL_WREN,
                                                          sncs_pkg::ST_OK, 24'd0);
                                    n_bel   = '0;
                                    n_phase = PH_WE;
                                end
                            end else if (r_poll >= limit) begin
                                b = sncs_pkg::add_res(b, sncs_pkg::K_DONE, 8'd0,
                                                      sncs_pkg::ST_TIMEOUT, 24'd0);
                                n_phase = PH_IDLE;
                            end else begin
                                b = sncs_pkg::add_res(b, sncs_pkg::K_SEND, sncs_pkg::FL_RDSR,
                                                      sncs_pkg::ST_OK, 24'd0);
                                n_bel   = '0;
                                n_phase = post ? PH_POST_CMD : PH_PRE_CMD;
                            end
                        end
                        PH_WE: begin
                            b = sncs_pkg::add_res(b, sncs_pkg::K_REL, 8'd0, sncs_pkg::ST_OK, 24'd0);
                            b = sncs_pkg::add_res(b, sncs_pkg::K_SEND, sncs_pkg::FL_RDSR,
                                                  sncs_pkg::ST_OK, 24'd0);
                            n_bel   = '0;
                            n_phase = PH_WEL_CMD;
                        end
                        PH_WEL_CMD: begin
                            b = sncs_pkg::add_res(b, sncs_pkg::K_SEND, sncs_pkg::FL_DUMMY,
                                                  sncs_pkg::ST_OK, 24'd0);
                            n_bel   = '0;
                            n_phase = PH_WEL_STAT;
                        end
                        PH_WEL_STAT: begin
                            b = sncs_pkg::add_res(b, sncs_pkg::K_REL, 8'd0, sncs_pkg::ST_OK, 24'd0);
                            if (!i_data_in[1]) begin
                                b = sncs_pkg::add_res(b, sncs_pkg::K_DONE, 8'd0,
                                                      sncs_pkg::ST_VERIFY, 24'd0);
                                n_phase = PH_IDLE;
                            end else begin
                                b = sncs_pkg::add_res(b, sncs_pkg::K_SEND,
                                        (r_cmd == sncs_pkg::CMD_PROG) ? sncs_pkg::FL_PP :
                                        (r_cmd == sncs_pkg::CMD_SERASE) ? sncs_pkg::FL_SE :
                                        sncs_pkg::FL_CE, sncs_pkg::ST_OK, 24'd0);
                                n_bel   = '0;
                                n_phase = PH_CMD;
                            end
                        end
                        PH_CMD: begin
                            if (r_cmd == sncs_pkg::CMD_READ || r_cmd == sncs_pkg::CMD_PROG ||
                                r_cmd == sncs_pkg::CMD_SERASE) begin
                                n_aidx = '0;
                                b = sncs_pkg::add_res(b, sncs_pkg::K_SEND,
                                                      addr_byte(r_waddr, 2'd0, ac4),
                                                      sncs_pkg::ST_OK, 24'd0);
                                n_bel   = '0;
                                n_phase = PH_ADDR;
                            end else if (r_cmd == sncs_pkg::CMD_CERASE) begin
                                b = sncs_pkg::add_res(b, sncs_pkg::K_REL, 8'd0,
                                                      sncs_pkg::ST_OK, 24'd0);
                                n_poll = '0;
                                b = sncs_pkg::add_res(b, sncs_pkg::K_SEND, sncs_pkg::FL_RDSR,
                                                      sncs_pkg::ST_OK, 24'd0);
                                n_bel   = '0;
                                n_phase = PH_POST_CMD;
                            end else begin
                                b = sncs_pkg::add_res(b, sncs_pkg::K_REL, 8'd0,
                                                      sncs_pkg::ST_OK, 24'd0);
                                b = sncs_pkg::add_res(b, sncs_pkg::K_DELAY, 8'd0,
                                                      sncs_pkg::ST_OK, 24'd0);
                                b = sncs_pkg::add_res(b, sncs_pkg::K_DONE, 8'd0,
                                                      sncs_pkg::ST_OK, 24'd0);
                                n_phase = PH_IDLE;
                            end
                        end
                        PH_ADDR: begin
                            if (({1'b0, r_aidx} + 3'd1) < (ac4 ? 3'd4 : 3'd3)) begin
                                n_aidx = aidx_inc;
                                b = sncs_pkg::add_res(b, sncs_pkg::K_SEND,
                                                      addr_byte(r_waddr, aidx_inc, ac4),
                                                      sncs_pkg::ST_OK, 24'd0);
                                n_bel = '0;
                            end else if (r_cmd == sncs_pkg::CMD_READ) begin
                                b = sncs_pkg::add_res(b, sncs_pkg::K_SEND, sncs_pkg::FL_DUMMY,
                                                      sncs_pkg::ST_OK, 24'd0);
                                n_bel   = '0;
                                n_phase = PH_READ;
                            end else if (r_cmd == sncs_pkg::CMD_PROG) begin
                                b = sncs_pkg::add_res(b, sncs_pkg::K_NEED, 8'd0,
                                                      sncs_pkg::ST_OK, 24'd0);
                                n_phase = PH_HOST;
                            end else begin
                                b = sncs_pkg::add_res(b, sncs_pkg::K_REL, 8'd0,
                                                      sncs_pkg::ST_OK, 24'd0);
                                n_poll = '0;
                                b = sncs_pkg::add_res(b, sncs_pkg::K_SEND, sncs_pkg::FL_RDSR,
                                                      sncs_pkg::ST_OK, 24'd0);
                                n_bel   = '0;
                                n_phase = PH_POST_CMD;
                            end
                        end
                        PH_READ: begin
                            b = sncs_pkg::add_res(b, sncs_pkg::K_RDBYTE, i_data_in,
                                                  sncs_pkg::ST_OK, 24'd0);
                            n_left = r_left - 32'd1;
                            if (r_left != 32'd1) begin
                                b = sncs_pkg::add_res(b, sncs_pkg::K_SEND, sncs_pkg::FL_DUMMY,
                                                      sncs_pkg::ST_OK, 24'd0);
                                n_bel = '0;
                            end else begin
                                b = sncs_pkg::add_res(b, sncs_pkg::K_REL, 8'd0,
                                                      sncs_pkg::ST_OK, 24'd0);
                                b = sncs_pkg::add_res(b, sncs_pkg::K_DONE, 8'd0,
                                                      sncs_pkg::ST_OK, 24'd0);
                                n_phase = PH_IDLE;
                            end
                        end
                        PH_PROG: begin
                            n_left = r_left - 32'd1;
                            if (r_left != 32'd1) begin
                                b = sncs_pkg::add_res(b, sncs_pkg::K_NEED, 8'd0,
                                                      sncs_pkg::ST_OK, 24'd0);
                                n_phase = PH_HOST;
                            end else begin
                                b = sncs_pkg::add_res(b, sncs_pkg::K_REL, 8'd0,
                                                      sncs_pkg::ST_OK, 24'd0);
                                n_poll = '0;
                                b = sncs_pkg::add_res(b, sncs_pkg::K_SEND, sncs_pkg::FL_RDSR,
                                                      sncs_pkg::ST_OK, 24'd0);
                                n_bel   = '0;
                                n_phase = PH_POST_CMD;
                            end
                        end
                        default: begin
                            n_phase = r_phase;
                        end
                    endcase
                end
                sncs_pkg::OP_TICK: begin
                    if (r_phase != PH_IDLE && r_phase != PH_HOST) begin
                        if ((r_phase == PH_PRE_CMD || r_phase == PH_PRE_STAT ||
                             r_phase == PH_POST_CMD || r_phase == PH_POST_STAT) &&
                            r_poll != sncs_pkg::POLL_MAX) begin
                            n_poll = r_poll + 18'd1;
                        end
                        n_bel = bel_inc;
                        if (bel_inc >= i_cfg.byte_to) begin
                            b = sncs_pkg::add_res(b, sncs_pkg::K_REL, 8'd0, sncs_pkg::ST_OK, 24'd0);
                            if (r_phase == PH_WAKE) begin
                                b = sncs_pkg::add_res(b, sncs_pkg::K_DELAY, 8'd0,
                                                      sncs_pkg::ST_OK, 24'd0);
                                if (r_cmd == sncs_pkg::CMD_INIT) begin
                                    n_id   = '0;
                                    n_aidx = '0;
                                    b = sncs_pkg::add_res(b, sncs_pkg::K_SEND,
                                                          sncs_pkg::FL_RDID,
                                                          sncs_pkg::ST_OK, 24'd0);
                                    n_bel   = '0;
                                    n_phase = PH_ID_CMD;
                                end else begin
                                    b = sncs_pkg::add_res(b, sncs_pkg::K_DONE, 8'd0,
                                                          sncs_pkg::ST_TIMEOUT, 24'd0);
                                    n_phase = PH_IDLE;
                                end
                            end else begin
                                if (r_phase == PH_CMD && r_cmd == sncs_pkg::CMD_PDOWN) begin
                                    b = sncs_pkg::add_res(b, sncs_pkg::K_DELAY, 8'd0,
                                                          sncs_pkg::ST_OK, 24'd0);
                                end
                                b = sncs_pkg::add_res(b, sncs_pkg::K_DONE, 8'd0,
                                                      sncs_pkg::ST_TIMEOUT, 24'd0);
                                n_phase = PH_IDLE;
                            end
                        end
                    end
                end
                sncs_pkg::OP_WBYTE: begin
                    if (r_phase == PH_HOST) begin
                        b = sncs_pkg::add_res(b, sncs_pkg::K_SEND, i_data_in,
                                              sncs_pkg::ST_OK, 24'd0);
                        n_bel   = '0;
                        n_phase = PH_PROG;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    assign o_push   = i_accept && (b.cnt != 3'd0);
    assign o_bundle = b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_cmd   <= '0;
            r_waddr <= '0;
            r_left  <= '0;
            r_aidx  <= '0;
            r_poll  <= '0;
            r_bel   <= '0;
            r_id    <= '0;
            r_bus   <= 1'b0;
            r_init  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_cmd   <= n_cmd;
            r_waddr <= n_waddr;
            r_left  <= n_left;
            r_aidx  <= n_aidx;
            r_poll  <= n_poll;
            r_bel   <= n_bel;
            r_id    <= n_id;
            r_bus   <= n_bus;
            r_init  <= n_init;
        end
    end

endmodule
`default_nettype wire

/* sv/sncs_queue.sv */
// Short bundle queue between the front end and the beat serializer.
`timescale 1ns / 1ps
`default_nettype none
module sncs_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire sncs_pkg::t_bundle i_data,
    input  wire logic              i_pop,
    output logic                   o_full,
    output logic                   o_empty,
    output sncs_pkg::t_bundle      o_data
);

    // two fixed slots: the head is always presented, the tail moves up on pop
    sncs_pkg::t_bundle r_head, r_tail;
    logic [1:0]        r_cnt;

    assign o_full  = (r_cnt == 2'(sncs_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_head;

    always_ff @(posedge i_clk) begin
        if (i_pop && r_cnt == 2'd2) begin
            r_head <= r_tail;
        end else if (i_push && (r_cnt == 2'd0 || i_pop)) begin
            r_head <= i_data;
        end
        if (i_push && !i_pop && r_cnt == 2'd1) begin
            r_tail <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule
`default_nettype wire

/* sv/sncs_back.sv */
// Back end: holds one bundle and drains it as result beats.
`timescale 1ns / 1ps
`default_nettype none
module sncs_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire sncs_pkg::t_bundle i_bundle,
    output logic                   o_pop,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output sncs_pkg::t_res         o_res,
    output logic                   o_last
);

    sncs_pkg::t_bundle r_cur;
    logic [1:0]        r_idx;
    logic              r_full;
    logic [1:0]        last_idx;
    logic              drained;

    assign last_idx = r_cur.cnt[1:0] - 2'd1;
    assign o_last   = (r_idx == last_idx);
    assign o_valid  = r_full;
    assign o_res    = r_cur.res[r_idx];
    assign drained  = r_full && i_ready && o_last;
    assign o_pop    = i_valid && (!r_full || drained);

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_bundle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
            r_idx  <= '0;
        end else if (o_pop) begin
            r_full <= 1'b1;
            r_idx  <= '0;
        end else if (r_full && i_ready) begin
            // advance within the bundle, drop it after its last beat
            if (o_last) begin
                r_full <= 1'b0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

endmodule
`default_nettype wire

/* sv/spi_nor_flash_command_sequencer.sv */
// Top level of the serial NOR flash command sequencer.
`timescale 1ns / 1ps
`default_nettype none
// Serial NOR flash command sequencer. Host requests, SPI reply bytes, host
// write bytes and millisecond ticks enter on the slave stream (tuser holds the
// item kind); the master stream carries the bytes to shift out, select
// releases, read data, write-byte requests, delay marks and the completion
// beat with its status and JEDEC id. tlast marks the final beat caused by one
// input beat; a beat that causes nothing produces no output. The front end
// takes one input beat per clock whenever the two-entry bundle queue has room,
// so input and output stall independently. Each input beat yields up to three
// output beats and the back end sends one beat per clock while i_m_tready is
// high, so sustained throughput is one input beat per cycle for beats with at
// most one result and otherwise set by the output rate of one beat per clock.
// The user must write configuration registers through i_cfg_we/i_cfg_idx/
// i_cfg_data only while the block is idle; the block does not enforce this.
// PAGE_BYTES and SECTOR_BYTES set the page bound check and the erase alignment.
module spi_nor_flash_command_sequencer #(
    parameter int unsigned PAGE_BYTES   = sncs_pkg::PAGE_BYTES_DEF,
    parameter int unsigned SECTOR_BYTES = sncs_pkg::SECTOR_BYTES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // [2:0] command, [34:3] address, [66:35] length, [74:67] data_in, [79:75] zero
    input  wire logic [79:0] i_s_tdata,
    // [1:0] op
    input  wire logic [1:0]  i_s_tuser,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // [7:0] byte_out, [10:8] status, [34:11] device_id, [39:35] zero
    output logic [39:0]      o_m_tdata,
    // [2:0] kind
    output logic [2:0]       o_m_tuser,
    output logic             o_m_tlast
);

    sncs_pkg::t_cfg    r_cfg;
    sncs_pkg::t_bundle push_bundle, head_bundle;
    sncs_pkg::t_res    out_res;
    logic              accept, push, pop, q_full, q_empty;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.abc     <= 3'd3;
            r_cfg.cap     <= 32'd16777216;
            r_cfg.exp_id  <= 24'd15679512;
            r_cfg.byte_to <= 8'd10;
            r_cfg.page_to <= 16'd100;
            r_cfg.sec_to  <= 16'd3000;
            r_cfg.chip_to <= 18'd200000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sncs_pkg::REG_ABC:    r_cfg.abc     <= i_cfg_data[2:0];
                sncs_pkg::REG_CAP:    r_cfg.cap     <= i_cfg_data;
                sncs_pkg::REG_ID:     r_cfg.exp_id  <= i_cfg_data[23:0];
                sncs_pkg::REG_BYTETO: r_cfg.byte_to <= i_cfg_data[7:0];
                sncs_pkg::REG_PAGETO: r_cfg.page_to <= i_cfg_data[15:0];
                sncs_pkg::REG_SECTO:  r_cfg.sec_to  <= i_cfg_data[15:0];
                sncs_pkg::REG_CHIPTO: r_cfg.chip_to <= i_cfg_data[17:0];
                default:              r_cfg         <= r_cfg;
            endcase
        end
    end

    // take a beat whenever the queue can hold its bundle
    assign o_s_tready = !q_full;
    assign accept     = i_s_tvalid && o_s_tready;

    sncs_front #(
        .PAGE_BYTES   (PAGE_BYTES),
        .SECTOR_BYTES (SECTOR_BYTES)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_op      (i_s_tuser),
        .i_command (i_s_tdata[2:0]),
        .i_address (i_s_tdata[34:3]),
        .i_length  (i_s_tdata[66:35]),
        .i_data_in (i_s_tdata[74:67]),
        .i_cfg     (r_cfg),
        .o_push    (push),
        .o_bundle  (push_bundle)
    );

    sncs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_bundle),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_data  (head_bundle)
    );

    sncs_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (!q_empty),
        .i_bundle (head_bundle),
        .o_pop    (pop),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_res    (out_res),
        .o_last   (o_m_tlast)
    );

    assign o_m_tuser = out_res.kind;
    assign o_m_tdata = {5'd0, out_res.device_id, out_res.status, out_res.byte_out};

`ifndef SYNTH
    // nothing leaves the block in the cycle after reset
    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("output beat right after reset");
    // a completion beat always closes the beats of its input
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser == sncs_pkg::K_DONE) |-> o_m_tlast)
        else $error("done beat without tlast");
    // status only travels on completion beats
    a_status_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser != sncs_pkg::K_DONE) |-> (o_m_tdata[10:8] == sncs_pkg::ST_OK))
        else $error("status on a non-done beat");
`endif

endmodule
`default_nettype wire
